// ===== hw/rtl/frmb_pkg.sv =====
// Shared types, constants and codes of the frame builder with XOR parity.
package frmb_pkg;

    localparam int DEF_MIN_PAYLOAD = 10;
    localparam logic [7:0] MARKER_RESET = 8'd126;

    localparam logic REG_START_MARKER = 1'b0;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    typedef enum logic [2:0] {
        SEL_MARKER,
        SEL_HDR1,
        SEL_HDR2,
        SEL_DATA,
        SEL_ERR,
        SEL_PAD,
        SEL_PARITY
    } t_sel;

    typedef struct packed {
        logic emit;
        t_sel sel;
        logic load_hdr;
        logic dec_bytes;
        logic dec_pad;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic frame_open;
        logic last_data;
        logic len_zero;
        logic pad_zero;
        logic pad_one;
    } t_sts;

endpackage

// ===== hw/rtl/frmb_ctrl.sv =====
// Controller state machine of the frame builder: sequences marker, headers, data, padding, parity and error bytes.
module frmb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_action,
    input  frmb_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output frmb_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_HDR1   = 5'b00010,
        ST_HDR2   = 5'b00100,
        ST_PAD    = 5'b01000,
        ST_PARITY = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE) && i_sts.out_free;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.sel       = frmb_pkg::SEL_PAD;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_action == frmb_pkg::ACT_START) begin
                        o_cmd.sel      = frmb_pkg::SEL_MARKER;
                        o_cmd.load_hdr = 1'b1;
                        n_state        = ST_HDR1;
                    end else if (!i_sts.frame_open) begin
                        o_cmd.sel = frmb_pkg::SEL_ERR;
                    end else begin
                        o_cmd.sel       = frmb_pkg::SEL_DATA;
                        o_cmd.dec_bytes = 1'b1;
                        if (i_sts.last_data) begin
                            n_state = i_sts.pad_zero ? ST_PARITY : ST_PAD;
                        end
                    end
                end
            end
            ST_HDR1: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = frmb_pkg::SEL_HDR1;
                    n_state    = ST_HDR2;
                end
            end
            ST_HDR2: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = frmb_pkg::SEL_HDR2;
                    if (i_sts.len_zero) begin
                        n_state = i_sts.pad_zero ? ST_PARITY : ST_PAD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.sel     = frmb_pkg::SEL_PAD;
                    o_cmd.dec_pad = 1'b1;
                    if (i_sts.pad_one) begin
                        n_state = ST_PARITY;
                    end
                end
            end
            ST_PARITY: begin
                if (i_sts.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.sel   = frmb_pkg::SEL_PARITY;
                    o_cmd.clear = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/frmb_dpath.sv =====
// Datapath of the frame builder: frame state, parity, start marker and output register.
module frmb_dpath #(
    parameter int MIN_PAYLOAD = frmb_pkg::DEF_MIN_PAYLOAD
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  frmb_pkg::t_cmd i_cmd,
    input  logic [5:0]     i_len,
    input  logic [5:0]     i_seq,
    input  logic [3:0]     i_kind,
    input  logic [7:0]     i_data,
    input  logic           i_marker_we,
    input  logic [7:0]     i_marker_wdata,
    input  logic           i_out_ready,
    output frmb_pkg::t_sts o_sts,
    output logic [7:0]     o_marker,
    output logic           o_out_valid,
    output logic [7:0]     o_out_byte,
    output logic           o_out_last,
    output logic           o_out_error
);

    localparam int PAD_W = (MIN_PAYLOAD > 1) ? $clog2(MIN_PAYLOAD + 1) : 1;
    localparam logic [6:0] MIN_P = 7'(MIN_PAYLOAD);

    logic             r_frame_open;
    logic [5:0]       r_bytes_left;
    logic [PAD_W-1:0] r_pad_left;
    logic [7:0]       r_parity;
    logic [7:0]       r_marker;
    logic [5:0]       r_len;
    logic [5:0]       r_seq;
    logic [3:0]       r_kind;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_last;
    logic             r_error;

    logic [7:0]       n_byte;
    logic [6:0]       pad_diff;
    logic [PAD_W-1:0] pad_init;

    assign pad_diff = MIN_P - {1'b0, i_len};
    assign pad_init = ({1'b0, i_len} < MIN_P) ? pad_diff[PAD_W-1:0] : '0;

    always_comb begin
        case (i_cmd.sel)
            frmb_pkg::SEL_MARKER: n_byte = r_marker;
            frmb_pkg::SEL_HDR1:   n_byte = {r_len, r_seq[5:4]};
            frmb_pkg::SEL_HDR2:   n_byte = {r_seq[3:0], r_kind};
            frmb_pkg::SEL_DATA:   n_byte = i_data;
            frmb_pkg::SEL_PARITY: n_byte = r_parity;
            default:              n_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_bytes_left <= '0;
            r_pad_left   <= '0;
            r_parity     <= '0;
            r_marker     <= frmb_pkg::MARKER_RESET;
            r_valid      <= 1'b0;
        end else begin
            if (i_marker_we) begin
                r_marker <= i_marker_wdata;
            end
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
            if (i_cmd.load_hdr) begin
                r_frame_open <= 1'b1;
                r_bytes_left <= i_len;
                r_pad_left   <= pad_init;
                r_parity     <= r_marker;
            end else if (i_cmd.clear) begin
                r_frame_open <= 1'b0;
                r_bytes_left <= '0;
                r_pad_left   <= '0;
                r_parity     <= '0;
            end else begin
                if (i_cmd.emit && (i_cmd.sel == frmb_pkg::SEL_HDR1 ||
                                   i_cmd.sel == frmb_pkg::SEL_HDR2 ||
                                   i_cmd.sel == frmb_pkg::SEL_DATA)) begin
                    r_parity <= r_parity ^ n_byte;
                end
                if (i_cmd.dec_bytes) begin
                    r_bytes_left <= r_bytes_left - 6'd1;
                end
                if (i_cmd.dec_pad) begin
                    r_pad_left <= r_pad_left - PAD_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_hdr) begin
            r_len  <= i_len;
            r_seq  <= i_seq;
            r_kind <= i_kind;
        end
        if (i_cmd.emit) begin
            r_byte  <= n_byte;
            r_last  <= (i_cmd.sel == frmb_pkg::SEL_PARITY);
            r_error <= (i_cmd.sel == frmb_pkg::SEL_ERR);
        end
    end

    assign o_sts.out_free   = !r_valid || i_out_ready;
    assign o_sts.frame_open = r_frame_open;
    assign o_sts.last_data  = (r_bytes_left == 6'd1);
    assign o_sts.len_zero   = (r_bytes_left == 6'd0);
    assign o_sts.pad_zero   = (r_pad_left == '0);
    assign o_sts.pad_one    = (r_pad_left == PAD_W'(1));

    assign o_marker    = r_marker;
    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_out_last  = r_last;
    assign o_out_error = r_error;

endmodule

// ===== hw/rtl/frame_builder_xor_parity_top.sv =====
// Top level of the frame builder with XOR parity.
// The input stream carries requests: tuser 0 is a start transaction whose tdata holds the
// payload length, sequence number and type; tuser 1 carries one payload byte in tdata.
// The output stream carries the frame one byte per transaction: the start marker, two
// header bytes, the payload bytes, zero padding up to MIN_PAYLOAD bytes and a parity byte
// flagged by tlast. tuser marks an error byte sent for data with no frame open.
// A start transaction emits the marker and then the two header bytes; with an empty payload
// the padding bytes and the parity byte follow. A payload byte emits one data byte, and the
// last one of a frame is followed by the padding bytes and then the parity byte. The output
// register holds one byte, so the first result appears in the cycle after acceptance; the
// state machine emits one output byte per cycle while the output register is free.
// The APB port holds the start marker register at address 0; writes are taken at once.
// Reset clears the frame state, empties the output register and sets the marker to 126.
// When the receiver stalls, the output byte holds and input is refused once it is full.
module frame_builder_xor_parity_top #(
    parameter int MIN_PAYLOAD = frmb_pkg::DEF_MIN_PAYLOAD
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: payload_length[5:0], sequence_req[11:6], kind[15:12], data_byte[23:16]
    input  logic [23:0] i_s_axis_tdata,
    // tuser: action[0]
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: frame_byte[7:0]
    output logic [7:0]  o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    // tuser: error[0]
    output logic        o_m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    frmb_pkg::t_cmd cmd;
    frmb_pkg::t_sts sts;
    logic           marker_we;
    logic [7:0]     marker;

    assign pready    = 1'b1;
    assign marker_we = psel && penable && pwrite && (paddr[2] == frmb_pkg::REG_START_MARKER);
    assign prdata    = (paddr[2] == frmb_pkg::REG_START_MARKER) ? {24'd0, marker} : 32'd0;

    frmb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_action   (i_s_axis_tuser),
        .i_sts      (sts),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    frmb_dpath #(
        .MIN_PAYLOAD (MIN_PAYLOAD)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_len          (i_s_axis_tdata[5:0]),
        .i_seq          (i_s_axis_tdata[11:6]),
        .i_kind         (i_s_axis_tdata[15:12]),
        .i_data         (i_s_axis_tdata[23:16]),
        .i_marker_we    (marker_we),
        .i_marker_wdata (pwdata[7:0]),
        .i_out_ready    (i_m_axis_tready),
        .o_sts          (sts),
        .o_marker       (marker),
        .o_out_valid    (o_m_axis_tvalid),
        .o_out_byte     (o_m_axis_tdata),
        .o_out_last     (o_m_axis_tlast),
        .o_out_error    (o_m_axis_tuser)
    );

endmodule
